/* design/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

	localparam int PRIO_BITS  = 32;
	localparam int DATA_BITS  = 32;
	localparam int COUNT_BITS = 5;

	typedef enum logic {
		CMD_INSERT  = 1'b0,
		CMD_DEQUEUE = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic ins;
		logic deq;
	} cell_ctrl_t;

	typedef struct packed {
		status_t                      status;
		logic [DATA_BITS-1:0]         removed_data;
		logic signed [PRIO_BITS-1:0]  removed_priority;
		logic [DATA_BITS-1:0]         head_data;
		logic signed [PRIO_BITS-1:0]  head_priority;
		logic                         is_empty;
		logic [COUNT_BITS-1:0]        entry_count;
	} result_t;

endpackage

/* design/spq_cell.sv */
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; #(
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                          clk,
	input  cell_ctrl_t                    ctrl,
	input  logic                          occupied,
	input  logic signed [PRIO_BITS-1:0]   new_prio,
	input  logic [PAYLOAD_BITS-1:0]       new_data,
	input  logic                          left_lt,
	input  logic signed [PRIO_BITS-1:0]   left_prio,
	input  logic [PAYLOAD_BITS-1:0]       left_data,
	input  logic signed [PRIO_BITS-1:0]   right_prio,
	input  logic [PAYLOAD_BITS-1:0]       right_data,
	output logic                          lt,
	output logic signed [PRIO_BITS-1:0]   prio,
	output logic [PAYLOAD_BITS-1:0]       data,
	output logic signed [PRIO_BITS-1:0]   next_prio,
	output logic [PAYLOAD_BITS-1:0]       next_data
);

	logic signed [PRIO_BITS-1:0] prio_q;
	logic [PAYLOAD_BITS-1:0]     data_q;

	// new entry belongs in front of this slot
	assign lt = !occupied || (prio_q < new_prio);

	always_comb begin
		next_prio = prio_q;
		next_data = data_q;
		if (ctrl.ins && lt) begin
			if (left_lt) begin
				next_prio = left_prio;
				next_data = left_data;
			end else begin
				next_prio = new_prio;
				next_data = new_data;
			end
		end else if (ctrl.deq) begin
			next_prio = right_prio;
			next_data = right_data;
		end
	end

	always_ff @(posedge clk) begin
		prio_q <= next_prio;
		data_q <= next_data;
	end

	assign prio = prio_q;
	assign data = data_q;

endmodule

/* design/sorted_priority_queue_core.sv */
`timescale 1ns / 1ps

// Max-priority queue of QUEUE_DEPTH entries held as a sorted row of cells, slot 0 holding the
// highest priority. Each beat is an insert (command 0) or a dequeue of the head (command 1);
// every cell compares its own priority with the incoming one in parallel and either keeps its
// entry, takes its neighbour's or takes the new one, so one beat is taken per clock cycle while
// the skid entry is empty, its result registered in the output buffer. Equal priorities leave
// in arrival order. An insert into a full queue is dropped with status 1, a dequeue from an
// empty queue returns status 2. Each result also reports the head, the empty flag and the count
// after the beat. A two-entry output buffer lets input beats keep flowing while one result waits.

module sorted_priority_queue_core import spq_pkg::*; #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic                         command,
	input  logic [DATA_BITS-1:0]         item_data,
	input  logic signed [PRIO_BITS-1:0]  item_priority,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [1:0]                   status,
	output logic [DATA_BITS-1:0]         removed_data,
	output logic signed [PRIO_BITS-1:0]  removed_priority,
	output logic [DATA_BITS-1:0]         head_data,
	output logic signed [PRIO_BITS-1:0]  head_priority,
	output logic                         is_empty,
	output logic [COUNT_BITS-1:0]        entry_count
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0] fill_q;
	logic [CW-1:0] fill_d;
	logic          full;
	logic          empty;
	logic          accept;
	cell_ctrl_t    ctrl;

	logic [PAYLOAD_BITS-1:0]      new_data;
	logic                         lt        [QUEUE_DEPTH];
	logic signed [PRIO_BITS-1:0]  prio      [QUEUE_DEPTH];
	logic [PAYLOAD_BITS-1:0]      data      [QUEUE_DEPTH];
	logic signed [PRIO_BITS-1:0]  next_prio [QUEUE_DEPTH];
	logic [PAYLOAD_BITS-1:0]      next_data [QUEUE_DEPTH];

	logic [DATA_BITS-1:0]  head_ext;
	logic [DATA_BITS-1:0]  slot0_ext;
	logic [COUNT_BITS-1:0] count_ext;

	result_t res;
	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    take;

	assign full   = (fill_q == CW'(QUEUE_DEPTH));
	assign empty  = (fill_q == '0);
	assign accept = item_valid && item_ready;

	assign ctrl.ins = accept && (command == CMD_INSERT) && !full;
	assign ctrl.deq = accept && (command == CMD_DEQUEUE) && !empty;

	always_comb begin
		fill_d = fill_q;
		if (ctrl.ins) begin
			fill_d = fill_q + CW'(1);
		end else if (ctrl.deq) begin
			fill_d = fill_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_d;
		end
	end

	generate
		if (PAYLOAD_BITS > DATA_BITS) begin : g_wide
			assign new_data = {{(PAYLOAD_BITS-DATA_BITS){1'b0}}, item_data};
		end else begin : g_narrow
			assign new_data = item_data[PAYLOAD_BITS-1:0];
		end

		if (PAYLOAD_BITS >= DATA_BITS) begin : g_out_trunc
			assign head_ext  = next_data[0][DATA_BITS-1:0];
			assign slot0_ext = data[0][DATA_BITS-1:0];
		end else begin : g_out_pad
			assign head_ext  = {{(DATA_BITS-PAYLOAD_BITS){1'b0}}, next_data[0]};
			assign slot0_ext = {{(DATA_BITS-PAYLOAD_BITS){1'b0}}, data[0]};
		end

		if (CW >= COUNT_BITS) begin : g_cnt_trunc
			assign count_ext = fill_d[COUNT_BITS-1:0];
		end else begin : g_cnt_pad
			assign count_ext = {{(COUNT_BITS-CW){1'b0}}, fill_d};
		end

		for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
			logic                         left_lt;
			logic signed [PRIO_BITS-1:0]  left_prio;
			logic [PAYLOAD_BITS-1:0]      left_data;
			logic signed [PRIO_BITS-1:0]  right_prio;
			logic [PAYLOAD_BITS-1:0]      right_data;

			if (i == 0) begin : g_first
				assign left_lt   = 1'b0;
				assign left_prio = '0;
				assign left_data = '0;
			end else begin : g_mid
				assign left_lt   = lt[i-1];
				assign left_prio = prio[i-1];
				assign left_data = data[i-1];
			end

			if (i == QUEUE_DEPTH - 1) begin : g_last
				assign right_prio = prio[i];
				assign right_data = data[i];
			end else begin : g_inner
				assign right_prio = prio[i+1];
				assign right_data = data[i+1];
			end

			spq_cell #(
				.PAYLOAD_BITS(PAYLOAD_BITS)
			) u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.occupied   (fill_q > CW'(i)),
				.new_prio   (item_priority),
				.new_data   (new_data),
				.left_lt    (left_lt),
				.left_prio  (left_prio),
				.left_data  (left_data),
				.right_prio (right_prio),
				.right_data (right_data),
				.lt         (lt[i]),
				.prio       (prio[i]),
				.data       (data[i]),
				.next_prio  (next_prio[i]),
				.next_data  (next_data[i])
			);
		end
	endgenerate

	always_comb begin
		res.status           = ST_OK;
		res.removed_data     = '0;
		res.removed_priority = '0;
		if ((command == CMD_INSERT) && full) begin
			res.status = ST_FULL;
		end else if ((command == CMD_DEQUEUE) && empty) begin
			res.status = ST_EMPTY;
		end
		if (ctrl.deq) begin
			res.removed_data     = slot0_ext;
			res.removed_priority = prio[0];
		end
		res.is_empty      = (fill_d == '0);
		res.head_data     = res.is_empty ? '0 : head_ext;
		res.head_priority = res.is_empty ? '0 : next_prio[0];
		res.entry_count   = count_ext;
	end

	// output register plus skid entry
	assign item_ready = !skid_valid_q;
	assign take       = out_valid_q && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (take) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (accept) begin
				if (!out_valid_q || take) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (!out_valid_q || take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign result_valid     = out_valid_q;
	assign status           = out_q.status;
	assign removed_data     = out_q.removed_data;
	assign removed_priority = out_q.removed_priority;
	assign head_data        = out_q.head_data;
	assign head_priority    = out_q.head_priority;
	assign is_empty         = out_q.is_empty;
	assign entry_count      = out_q.entry_count;

endmodule

/* tb/sorted_priority_queue_core_tb.sv */
`timescale 1ns / 1ps

module sorted_priority_queue_core_tb;
	import spq_pkg::*;

	localparam int DEPTH       = 16;
	localparam int PHASE_BEATS = 650;
	localparam int CYCLE_LIMIT = 200000;

	class queue_shadow;
		logic signed [PRIO_BITS-1:0] slot_prio [DEPTH];
		logic [DATA_BITS-1:0]        slot_data [DEPTH];
		int                          fill;
		result_t                     due_outcomes [$];
		int                          failures;

		function new();
			fill     = 0;
			failures = 0;
		endfunction

		function void take_command(command_t cmd, logic [DATA_BITS-1:0] d,
				logic signed [PRIO_BITS-1:0] p);
			result_t want;
			int      pos;
			int      i;
			want        = '0;
			want.status = ST_OK;
			if (cmd == CMD_INSERT) begin
				if (fill == DEPTH) begin
					want.status = ST_FULL;
				end else begin
					pos = fill;
					for (i = fill - 1; i >= 0; i--)
						if (slot_prio[i] < p) pos = i;
					for (i = fill; i > pos; i--) begin
						slot_prio[i] = slot_prio[i-1];
						slot_data[i] = slot_data[i-1];
					end
					slot_prio[pos] = p;
					slot_data[pos] = d;
					fill++;
				end
			end else begin
				if (fill == 0) begin
					want.status = ST_EMPTY;
				end else begin
					want.removed_data     = slot_data[0];
					want.removed_priority = slot_prio[0];
					for (i = 1; i < fill; i++) begin
						slot_prio[i-1] = slot_prio[i];
						slot_data[i-1] = slot_data[i];
					end
					fill--;
				end
			end
			if (fill > 0) begin
				want.head_data     = slot_data[0];
				want.head_priority = slot_prio[0];
				want.is_empty      = 1'b0;
			end else begin
				want.is_empty = 1'b1;
			end
			want.entry_count = fill[COUNT_BITS-1:0];
			due_outcomes.push_back(want);
		endfunction

		function void check_outcome(result_t got);
			result_t want;
			if (due_outcomes.size() == 0) begin
				$display("%0t: result beat with none due, expected nothing, actual %h",
					$time, got);
				failures++;
				return;
			end
			want = due_outcomes.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status,
					got.status);
				failures++;
			end
			if (got.removed_data !== want.removed_data) begin
				$display("%0t: removed_data expected %h actual %h", $time,
					want.removed_data, got.removed_data);
				failures++;
			end
			if (got.removed_priority !== want.removed_priority) begin
				$display("%0t: removed_priority expected %0d actual %0d", $time,
					want.removed_priority, got.removed_priority);
				failures++;
			end
			if (got.head_data !== want.head_data) begin
				$display("%0t: head_data expected %h actual %h", $time,
					want.head_data, got.head_data);
				failures++;
			end
			if (got.head_priority !== want.head_priority) begin
				$display("%0t: head_priority expected %0d actual %0d", $time,
					want.head_priority, got.head_priority);
				failures++;
			end
			if (got.is_empty !== want.is_empty) begin
				$display("%0t: is_empty expected %b actual %b", $time, want.is_empty,
					got.is_empty);
				failures++;
			end
			if (got.entry_count !== want.entry_count) begin
				$display("%0t: entry_count expected %0d actual %0d", $time,
					want.entry_count, got.entry_count);
				failures++;
			end
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        item_valid;
	logic                        item_ready;
	logic                        command;
	logic [DATA_BITS-1:0]        item_data;
	logic signed [PRIO_BITS-1:0] item_priority;
	logic                        result_valid;
	logic                        result_ready;
	logic [1:0]                  status;
	logic [DATA_BITS-1:0]        removed_data;
	logic signed [PRIO_BITS-1:0] removed_priority;
	logic [DATA_BITS-1:0]        head_data;
	logic signed [PRIO_BITS-1:0] head_priority;
	logic                        is_empty;
	logic [COUNT_BITS-1:0]       entry_count;

	queue_shadow shadow;
	int          tx_idle_pct;
	int          rx_idle_pct;
	int          hold_cycles;
	int          cycle_count = 0;

	sorted_priority_queue_core #(
		.QUEUE_DEPTH  (DEPTH),
		.PAYLOAD_BITS (DATA_BITS)
	) i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_ready       (item_ready),
		.command          (command),
		.item_data        (item_data),
		.item_priority    (item_priority),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.status           (status),
		.removed_data     (removed_data),
		.removed_priority (removed_priority),
		.head_data        (head_data),
		.head_priority    (head_priority),
		.is_empty         (is_empty),
		.entry_count      (entry_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sorted_priority_queue_core regression: fail");
			$finish;
		end
	end

	// receiver side, long hold-offs counted here
	initial begin
		bit hold_done;
		hold_done    = 1'b0;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0 && !hold_done) begin
				result_ready <= 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_done = 1'b1;
			end
			result_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n && result_valid && result_ready) begin
			got.status           = status_t'(status);
			got.removed_data     = removed_data;
			got.removed_priority = removed_priority;
			got.head_data        = head_data;
			got.head_priority    = head_priority;
			got.is_empty         = is_empty;
			got.entry_count      = entry_count;
			shadow.check_outcome(got);
		end
	end

	task automatic send_beat(input command_t cmd, input logic [DATA_BITS-1:0] d,
			input logic signed [PRIO_BITS-1:0] p);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
		end
		item_valid    <= 1'b1;
		command       <= cmd;
		item_data     <= d;
		item_priority <= p;
		do @(posedge clk); while (!item_ready);
		shadow.take_command(cmd, d, p);
		@(negedge clk);
	endtask

	function automatic logic signed [PRIO_BITS-1:0] pick_priority();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return $signed($urandom_range(0, 7)) - 4;
		else if (roll < 60)
			return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
		else
			return $signed($urandom);
	endfunction

	initial begin
		int insert_pct;
		int phase;
		int n;
		shadow        = new();
		hold_cycles   = 0;
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		command       = CMD_INSERT;
		item_data     = '0;
		item_priority = '0;
		tx_idle_pct   = 6;
		rx_idle_pct   = 70;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty dequeue, extremes, equal priorities, full, three dequeues
		send_beat(CMD_DEQUEUE, 32'hffff_ffff, 32'sh7fff_ffff);
		send_beat(CMD_INSERT, 32'h0000_0000, 32'sh0000_0000);
		send_beat(CMD_INSERT, 32'hffff_ffff, 32'sh7fff_ffff);
		send_beat(CMD_INSERT, 32'h0000_0001, 32'sh8000_0000);
		send_beat(CMD_INSERT, 32'h0000_0002, -32'sd1);
		send_beat(CMD_INSERT, 32'h0000_0003, 32'sh0000_0000);
		send_beat(CMD_INSERT, 32'h0000_0004, 32'sh7fff_ffff);
		send_beat(CMD_INSERT, 32'h0000_0005, 32'sh8000_0000);
		send_beat(CMD_INSERT, 32'ha5a5_a5a5, 32'sh0000_0001);
		for (n = 0; n < 8; n++)
			send_beat(CMD_INSERT, $urandom, pick_priority());
		send_beat(CMD_INSERT, 32'h5a5a_5a5a, 32'sh7fff_ffff);
		repeat (3) send_beat(CMD_DEQUEUE, $urandom, $signed($urandom));

		insert_pct = 50;
		for (phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 70 : 0;
			rx_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 6 : 0;
			for (n = 0; n < PHASE_BEATS; n++) begin
				if (phase == 2 && n == 100)
					hold_cycles = 150;
				if (n % 40 == 0) begin
					case ($urandom_range(0, 3))
						0: insert_pct = 25;
						1: insert_pct = 50;
						2: insert_pct = 75;
						default: insert_pct = 92;
					endcase
				end
				if ($urandom_range(0, 99) < insert_pct)
					send_beat(CMD_INSERT, $urandom, pick_priority());
				else
					send_beat(CMD_DEQUEUE, $urandom, $signed($urandom));
			end
		end
		item_valid <= 1'b0;

		while (shadow.due_outcomes.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (shadow.failures == 0)
			$display("sorted_priority_queue_core regression: pass");
		else
			$display("sorted_priority_queue_core regression: fail");
		$finish;
	end

endmodule
